// File: rtl/pgc_pkg.sv
package pgc_pkg;

    localparam int FINGER_COUNT = 4;
    localparam int FINGER_W     = 2;
    localparam int MODE_REGS    = 4;
    localparam int COORD_BITS   = 16;
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int RANGE_W      = 12;
    localparam int HOLD_W       = 16;
    localparam int TIME_W       = 32;
    localparam int AXIS_W       = 16;
    localparam int Q_ONE        = 16384;
    localparam int DIV_STEPS    = 14;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_THIRD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_FOURTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PINCH_DIST  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STICK_RANGE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DELAY  = 3'd6;

    typedef enum logic [2:0] {
        MODE_NONE   = 3'd0,
        MODE_PINCH  = 3'd1,
        MODE_TIMED  = 3'd2,
        MODE_DOUBLE = 3'd3,
        MODE_STICK  = 3'd4,
        MODE_LOCKED = 3'd5,
        MODE_SWIPE  = 3'd6
    } mode_t;

    typedef struct packed {
        logic                 start;
        logic                 neg;
        logic [DIFF_BITS-1:0] mag;
        logic [RANGE_W-1:0]   range;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [AXIS_W-1:0] quot;
    } div_rsp_t;

endpackage

// File: rtl/pinch_gesture_classifier.sv
// Pinch gesture classifier. Each transfer on the input carries one finger's tip, the thumb tip
// and a millisecond time stamp; each produces exactly one result transfer carrying click,
// thumbstick axes (Q1.14, clamped to +-1), stick-held and swipe flags for that finger, chosen
// by the finger's mode register. The pinch test runs on one shared 17x17 multiplier used four
// times (three squared distances and the squared threshold) in states MUL_X, MUL_Y, MUL_Z and
// MUL_T, followed by DECIDE and FINISH; a finger in mode none goes straight to FINISH. In the
// two stick modes, while the stick is active, a shared restoring divider runs once per axis
// between DECIDE and FINISH. The input is not ready while an item is in work; a finished
// result waits in the output register while the next item is taken, and a stalled output
// holds the block before it can take the following one.
module pinch_gesture_classifier
    import pgc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // thumb_x, thumb_y, thumb_z, tip_x, tip_y, tip_z, time_ms
    input  logic [127:0]          s_tdata,
    // finger_select
    input  logic [FINGER_W-1:0]   s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // click, stick_x, stick_y, stick_held, swipe_up, swipe_down, zero pad
    output logic [39:0]           m_tdata,
    // finger_id
    output logic [FINGER_W-1:0]   m_tuser
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_MUL_Z,
        ST_MUL_T,
        ST_DECIDE,
        ST_DIVX_GO,
        ST_DIVX_WAIT,
        ST_DIVZ_GO,
        ST_DIVZ_WAIT,
        ST_FINISH
    } state_t;

    logic [2:0]          mode_reg [MODE_REGS];
    logic [RANGE_W-1:0]  pinch_dist_reg;
    logic [RANGE_W-1:0]  stick_range_reg;
    logic [HOLD_W-1:0]   hold_delay_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MODE_REGS; i++) begin
                mode_reg[i] <= MODE_NONE;
            end
            pinch_dist_reg  <= RANGE_W'(320);
            stick_range_reg <= RANGE_W'(800);
            hold_delay_reg  <= HOLD_W'(500);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MODE_FIRST, CFG_MODE_SECOND, CFG_MODE_THIRD, CFG_MODE_FOURTH: begin
                    mode_reg[cfg_index[FINGER_W-1:0]] <= cfg_wdata[2:0];
                end
                CFG_PINCH_DIST:  pinch_dist_reg  <= cfg_wdata[RANGE_W-1:0];
                CFG_STICK_RANGE: stick_range_reg <= cfg_wdata[RANGE_W-1:0];
                CFG_HOLD_DELAY:  hold_delay_reg  <= cfg_wdata[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    state_t                       state_reg;
    logic [FINGER_W-1:0]          fsel_reg;
    logic [2:0]                   mode_cur_reg;
    logic signed [COORD_BITS-1:0] th_x_reg, th_y_reg, th_z_reg;
    logic signed [COORD_BITS-1:0] tp_x_reg, tp_y_reg, tp_z_reg;
    logic [TIME_W-1:0]            now_reg;

    logic [2*COORD_BITS:0]        prod_reg, prod_next;
    logic [2*COORD_BITS+1:0]      acc_reg;

    logic                         pl_reg    [FINGER_COUNT];
    logic [1:0]                   pc_reg    [FINGER_COUNT];
    logic [TIME_W-1:0]            press_reg [FINGER_COUNT];
    logic [COORD_BITS-1:0]        orx_reg   [FINGER_COUNT];
    logic [COORD_BITS-1:0]        ory_reg   [FINGER_COUNT];
    logic [COORD_BITS-1:0]        orz_reg   [FINGER_COUNT];
    logic                         lock_reg  [FINGER_COUNT];
    logic                         ch_reg    [FINGER_COUNT];

    logic signed [DIFF_BITS-1:0]  ax_x_reg, ax_z_reg;
    logic                         res_click_reg, res_held_reg, res_up_reg, res_down_reg;
    logic signed [AXIS_W-1:0]     res_sx_reg, res_sy_reg;

    logic                         m_tvalid_reg;
    logic [FINGER_W-1:0]          out_finger_reg;
    logic                         out_click_reg, out_held_reg, out_up_reg, out_down_reg;
    logic signed [AXIS_W-1:0]     out_sx_reg, out_sy_reg;

    // shared multiplier
    logic signed [DIFF_BITS-1:0]   mul_a, mul_b;
    logic signed [2*DIFF_BITS-1:0] mul_p;

    always_comb begin
        case (state_reg)
            ST_MUL_X: mul_a = {th_x_reg[COORD_BITS-1], th_x_reg} - {tp_x_reg[COORD_BITS-1], tp_x_reg};
            ST_MUL_Y: mul_a = {th_y_reg[COORD_BITS-1], th_y_reg} - {tp_y_reg[COORD_BITS-1], tp_y_reg};
            ST_MUL_Z: mul_a = {th_z_reg[COORD_BITS-1], th_z_reg} - {tp_z_reg[COORD_BITS-1], tp_z_reg};
            ST_MUL_T: mul_a = signed'(DIFF_BITS'(pinch_dist_reg));
            default:  mul_a = '0;
        endcase
        mul_b     = mul_a;
        mul_p     = mul_a * mul_b;
        prod_next = mul_p[2*COORD_BITS:0];
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    // per-finger decision
    logic [RANGE_W-1:0]           range_eff;
    logic                         pinch, newpress;
    logic [COORD_BITS-1:0]        org_x, org_y, org_z;
    logic [TIME_W-1:0]            press_eff;
    logic [1:0]                   cnt_a, cnt_n;
    logic                         ch_n, lock_n, click_n, held_n, up_n, down_n;
    logic signed [DIFF_BITS-1:0]  ox, oy, oz;
    logic signed [DIFF_BITS+2:0]  oy4, r3;
    logic                         timed_hit;

    always_comb begin
        range_eff = (stick_range_reg == '0) ? RANGE_W'(1) : stick_range_reg;
        pinch     = acc_reg < {1'b0, prod_reg};
        newpress  = !pl_reg[fsel_reg] && pinch;
        org_x     = newpress ? tp_x_reg : orx_reg[fsel_reg];
        org_y     = newpress ? tp_y_reg : ory_reg[fsel_reg];
        org_z     = newpress ? tp_z_reg : orz_reg[fsel_reg];
        press_eff = newpress ? now_reg : press_reg[fsel_reg];
        cnt_a     = (newpress && pc_reg[fsel_reg] < 2'd2) ? 2'(pc_reg[fsel_reg] + 2'd1)
                                                          : pc_reg[fsel_reg];
        ox = {org_x[COORD_BITS-1], org_x} - {tp_x_reg[COORD_BITS-1], tp_x_reg};
        oy = {org_y[COORD_BITS-1], org_y} - {tp_y_reg[COORD_BITS-1], tp_y_reg};
        oz = {org_z[COORD_BITS-1], org_z} - {tp_z_reg[COORD_BITS-1], tp_z_reg};
        oy4 = {oy[DIFF_BITS-1], oy, 2'b00};
        r3  = signed'((DIFF_BITS+3)'(range_eff) + (DIFF_BITS+3)'({range_eff, 1'b0}));
        timed_hit = ({1'b0, press_eff} + (TIME_W+1)'(hold_delay_reg)) < {1'b0, now_reg};

        cnt_n   = cnt_a;
        ch_n    = ch_reg[fsel_reg];
        lock_n  = lock_reg[fsel_reg];
        click_n = 1'b0;
        held_n  = 1'b0;
        up_n    = 1'b0;
        down_n  = 1'b0;
        case (mode_cur_reg)
            MODE_PINCH: begin
                ch_n    = pinch;
                click_n = ch_n;
            end
            MODE_TIMED: begin
                if (!pinch) begin
                    ch_n = 1'b0;
                end else if (timed_hit) begin
                    ch_n = 1'b1;
                end
                click_n = ch_n;
            end
            MODE_DOUBLE: begin
                if (!pinch) begin
                    ch_n = 1'b0;
                end else if (cnt_a >= 2'd2) begin
                    ch_n  = 1'b1;
                    cnt_n = 2'd0;
                end
                click_n = ch_n;
            end
            MODE_STICK: begin
                held_n = pinch;
            end
            MODE_LOCKED: begin
                if (pinch && cnt_a >= 2'd2) begin
                    lock_n = !lock_n;
                    cnt_n  = 2'd0;
                end
                held_n = lock_n;
            end
            MODE_SWIPE: begin
                ch_n    = pinch;
                click_n = ch_n;
                up_n    = pinch && (oy4 > r3);
                down_n  = pinch && (oy4 < -r3);
            end
            default: ;
        endcase
    end

    div_req_t div_req;
    div_rsp_t div_rsp;

    always_comb begin
        div_req.start = (state_reg == ST_DIVX_GO) || (state_reg == ST_DIVZ_GO);
        div_req.neg   = (state_reg == ST_DIVZ_GO) ? ax_z_reg[DIFF_BITS-1] : ax_x_reg[DIFF_BITS-1];
        if (state_reg == ST_DIVZ_GO) begin
            div_req.mag = ax_z_reg[DIFF_BITS-1] ? DIFF_BITS'(-ax_z_reg) : DIFF_BITS'(ax_z_reg);
        end else begin
            div_req.mag = ax_x_reg[DIFF_BITS-1] ? DIFF_BITS'(-ax_x_reg) : DIFF_BITS'(ax_x_reg);
        end
        div_req.range = range_eff;
    end

    pgc_axis_div u_axis_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_tready = (state_reg == ST_IDLE);

    logic out_load;

    assign out_load = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < FINGER_COUNT; i++) begin
                pl_reg[i]    <= 1'b0;
                pc_reg[i]    <= 2'd0;
                press_reg[i] <= '0;
                orx_reg[i]   <= '0;
                ory_reg[i]   <= '0;
                orz_reg[i]   <= '0;
                lock_reg[i]  <= 1'b0;
                ch_reg[i]    <= 1'b0;
            end
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        fsel_reg     <= s_tuser;
                        mode_cur_reg <= mode_reg[s_tuser];
                        th_x_reg     <= s_tdata[15:0];
                        th_y_reg     <= s_tdata[31:16];
                        th_z_reg     <= s_tdata[47:32];
                        tp_x_reg     <= s_tdata[63:48];
                        tp_y_reg     <= s_tdata[79:64];
                        tp_z_reg     <= s_tdata[95:80];
                        now_reg      <= s_tdata[127:96];
                        res_click_reg <= 1'b0;
                        res_held_reg  <= 1'b0;
                        res_up_reg    <= 1'b0;
                        res_down_reg  <= 1'b0;
                        res_sx_reg    <= '0;
                        res_sy_reg    <= '0;
                        if (mode_reg[s_tuser] inside {[MODE_PINCH:MODE_SWIPE]}) begin
                            state_reg <= ST_MUL_X;
                        end else begin
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_MUL_X: state_reg <= ST_MUL_Y;
                ST_MUL_Y: begin
                    acc_reg   <= {1'b0, prod_reg};
                    state_reg <= ST_MUL_Z;
                end
                ST_MUL_Z: begin
                    acc_reg   <= acc_reg + {1'b0, prod_reg};
                    state_reg <= ST_MUL_T;
                end
                ST_MUL_T: begin
                    acc_reg   <= acc_reg + {1'b0, prod_reg};
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    if (newpress) begin
                        orx_reg[fsel_reg]   <= tp_x_reg;
                        ory_reg[fsel_reg]   <= tp_y_reg;
                        orz_reg[fsel_reg]   <= tp_z_reg;
                        press_reg[fsel_reg] <= now_reg;
                    end
                    pl_reg[fsel_reg]   <= pinch;
                    pc_reg[fsel_reg]   <= cnt_n;
                    ch_reg[fsel_reg]   <= ch_n;
                    lock_reg[fsel_reg] <= lock_n;
                    res_click_reg <= click_n;
                    res_held_reg  <= held_n;
                    res_up_reg    <= up_n;
                    res_down_reg  <= down_n;
                    ax_x_reg      <= ox;
                    ax_z_reg      <= oz;
                    state_reg     <= held_n ? ST_DIVX_GO : ST_FINISH;
                end
                ST_DIVX_GO: state_reg <= ST_DIVX_WAIT;
                ST_DIVX_WAIT: begin
                    if (div_rsp.done) begin
                        res_sx_reg <= div_rsp.quot;
                        state_reg  <= ST_DIVZ_GO;
                    end
                end
                ST_DIVZ_GO: state_reg <= ST_DIVZ_WAIT;
                ST_DIVZ_WAIT: begin
                    if (div_rsp.done) begin
                        res_sy_reg <= div_rsp.quot;
                        state_reg  <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_load) begin
                        out_finger_reg <= fsel_reg;
                        out_click_reg  <= res_click_reg;
                        out_sx_reg     <= res_sx_reg;
                        out_sy_reg     <= res_sy_reg;
                        out_held_reg   <= res_held_reg;
                        out_up_reg     <= res_up_reg;
                        out_down_reg   <= res_down_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_finger_reg;
    assign m_tdata  = {4'b0000, out_down_reg, out_up_reg, out_held_reg,
                       out_sy_reg, out_sx_reg, out_click_reg};

endmodule

// File: rtl/pgc_axis_div.sv
module pgc_axis_div
    import pgc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    typedef enum logic {
        DIV_IDLE,
        DIV_RUN
    } div_state_t;

    localparam logic [AXIS_W-2:0] Q_FULL = (AXIS_W-1)'(Q_ONE);

    div_state_t           state_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [RANGE_W-1:0]   rem_reg;
    logic [RANGE_W-1:0]   range_reg;
    logic [AXIS_W-2:0]    quo_reg;
    logic                 neg_reg;
    logic                 done_reg;

    logic [RANGE_W:0]     rem_sh;
    logic                 fits;

    assign rem_sh = {rem_reg, 1'b0};
    assign fits   = rem_sh >= {1'b0, range_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                DIV_IDLE: begin
                    if (req.start) begin
                        neg_reg   <= req.neg;
                        range_reg <= req.range;
                        if (req.mag >= DIFF_BITS'(req.range)) begin
                            quo_reg  <= Q_FULL;
                            done_reg <= 1'b1;
                        end else begin
                            quo_reg   <= '0;
                            rem_reg   <= req.mag[RANGE_W-1:0];
                            cnt_reg   <= DIV_CNT_W'(DIV_STEPS);
                            state_reg <= DIV_RUN;
                        end
                    end
                end
                DIV_RUN: begin
                    if (fits) begin
                        rem_reg <= RANGE_W'(rem_sh - {1'b0, range_reg});
                    end else begin
                        rem_reg <= rem_sh[RANGE_W-1:0];
                    end
                    quo_reg <= {quo_reg[AXIS_W-3:0], fits};
                    cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                    if (cnt_reg == DIV_CNT_W'(1)) begin
                        done_reg  <= 1'b1;
                        state_reg <= DIV_IDLE;
                    end
                end
                default: begin
                    state_reg <= DIV_IDLE;
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = neg_reg ? -signed'({1'b0, quo_reg}) : signed'({1'b0, quo_reg});

endmodule

// File: rtl/pgc_checker.sv
module pgc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a transfer");

    a_swipe_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[34] && m_tdata[35]))
        else $error("swipe up and down both set");

    a_axes_need_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[33] |-> m_tdata[32:1] == 32'd0)
        else $error("stick axes set without stick held");

    a_click_vs_stick: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[33]))
        else $error("click and stick held both set");

endmodule

bind pinch_gesture_classifier pgc_checker u_pgc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: dv/tb_pinch_gesture_classifier.sv
module tb_pinch_gesture_classifier;
    import pgc_pkg::*;

    localparam logic [2:0] MODE_UNUSED = 3'd7;

    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    localparam int SETTLE_CYCLES = 50;

    typedef struct {
        logic [FINGER_W-1:0] finger;
        shortint             thx, thy, thz;
        shortint             tx, ty, tz;
        int unsigned         t;
    } frame_t;

    typedef struct {
        logic [FINGER_W-1:0]      finger_id;
        logic                     click;
        logic signed [AXIS_W-1:0] stick_x;
        logic signed [AXIS_W-1:0] stick_y;
        logic                     held;
        logic                     up;
        logic                     down;
    } gesture_t;

    typedef logic [CFG_DATA_W-1:0] reg_file_t [CFG_HOLD_DELAY + 1];

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [127:0]          s_tdata   = '0;
    logic [FINGER_W-1:0]   s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [39:0]           m_tdata;
    logic [FINGER_W-1:0]   m_tuser;

    pinch_gesture_classifier dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // classifier copy: configuration
    logic [2:0] mode_r [FINGER_COUNT] = '{default: MODE_NONE};
    int         pinch_dist = 320;
    int         stick_rng  = 800;
    int         hold_ms    = 500;

    // classifier copy: per-finger state
    logic        latched    [FINGER_COUNT] = '{default: 1'b0};
    logic [1:0]  pinch_cnt  [FINGER_COUNT] = '{default: 2'd0};
    int unsigned press_t    [FINGER_COUNT] = '{default: 0};
    shortint     org_x      [FINGER_COUNT] = '{default: 0};
    shortint     org_y      [FINGER_COUNT] = '{default: 0};
    shortint     org_z      [FINGER_COUNT] = '{default: 0};
    logic        locked     [FINGER_COUNT] = '{default: 1'b0};
    logic        click_held [FINGER_COUNT] = '{default: 1'b0};

    frame_t      pending_frames[$];
    gesture_t    expected_gestures[$];
    int          n_queued   = 0;
    int          n_accepted = 0;
    int          errors     = 0;
    int          idle_mode  = IDLE_NONE;
    int unsigned clock_ms   = 0;
    bit          s_took     = 1'b0;

    function automatic bit chance(int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic int rnd(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic logic signed [AXIS_W-1:0] to_axis(longint d, longint rng);
        longint q;
        q = d * Q_ONE / rng;
        if (q > Q_ONE) q = Q_ONE;
        if (q < -Q_ONE) q = -Q_ONE;
        return AXIS_W'(q);
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_MODE_FIRST, CFG_MODE_SECOND, CFG_MODE_THIRD, CFG_MODE_FOURTH: begin
                mode_r[idx] = val[2:0];
            end
            CFG_PINCH_DIST:  pinch_dist = val[RANGE_W-1:0];
            CFG_STICK_RANGE: stick_rng  = val[RANGE_W-1:0];
            CFG_HOLD_DELAY:  hold_ms    = val[HOLD_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic gesture_t classify(frame_t fr);
        gesture_t    g;
        logic [2:0]  md;
        int          f;
        longint      dx, dy, dz, d2, t2, rng, ox, oy, oz;
        logic        pinch;
        logic [32:0] due;
        g = '{default: '0};
        g.finger_id = fr.finger;
        f = fr.finger;
        md = mode_r[f];
        if (md == MODE_NONE || md == MODE_UNUSED) return g;

        dx = longint'(fr.thx) - longint'(fr.tx);
        dy = longint'(fr.thy) - longint'(fr.ty);
        dz = longint'(fr.thz) - longint'(fr.tz);
        d2 = dx * dx + dy * dy + dz * dz;
        t2 = longint'(pinch_dist) * pinch_dist;
        pinch = d2 < t2;
        rng = (stick_rng == 0) ? 1 : stick_rng;

        if (!latched[f] && pinch) begin
            org_x[f] = fr.tx;
            org_y[f] = fr.ty;
            org_z[f] = fr.tz;
            press_t[f] = fr.t;
            latched[f] = 1'b1;
            if (pinch_cnt[f] < 2) pinch_cnt[f]++;
        end
        if (!pinch) latched[f] = 1'b0;

        ox = longint'(org_x[f]) - longint'(fr.tx);
        oy = longint'(org_y[f]) - longint'(fr.ty);
        oz = longint'(org_z[f]) - longint'(fr.tz);

        case (md)
            MODE_PINCH: begin
                click_held[f] = pinch;
                g.click = click_held[f];
            end
            MODE_TIMED: begin
                due = 33'(press_t[f]) + 33'(hold_ms);
                if (!pinch) click_held[f] = 1'b0;
                else if (due < 33'(fr.t)) click_held[f] = 1'b1;
                g.click = click_held[f];
            end
            MODE_DOUBLE: begin
                if (!pinch) begin
                    click_held[f] = 1'b0;
                end else if (pinch_cnt[f] >= 2) begin
                    click_held[f] = 1'b1;
                    pinch_cnt[f] = 2'd0;
                end
                g.click = click_held[f];
            end
            MODE_STICK: begin
                if (pinch) begin
                    g.stick_x = to_axis(ox, rng);
                    g.stick_y = to_axis(oz, rng);
                    g.held = 1'b1;
                end
            end
            MODE_LOCKED: begin
                if (pinch && pinch_cnt[f] >= 2) begin
                    locked[f] = !locked[f];
                    pinch_cnt[f] = 2'd0;
                end
                if (locked[f]) begin
                    g.stick_x = to_axis(ox, rng);
                    g.stick_y = to_axis(oz, rng);
                    g.held = 1'b1;
                end
            end
            default: begin
                click_held[f] = pinch;
                g.click = click_held[f];
                if (pinch) begin
                    g.up   = 4 * oy > 3 * rng;
                    g.down = 4 * oy < -3 * rng;
                end
            end
        endcase
        return g;
    endfunction

    function automatic void compare_field(string name, logic signed [31:0] want,
                                          logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function automatic bit send_gap();
        case (idle_mode)
            IDLE_SEND: return chance(87);
            IDLE_BOTH: return chance(10);
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit recv_stall();
        case (idle_mode)
            IDLE_RECV: return chance(87);
            IDLE_BOTH: return chance(10);
            default:   return 1'b0;
        endcase
    endfunction

    always @(negedge aclk) begin
        frame_t fr;
        bit     go;
        if (aresetn && (!s_tvalid || s_took)) begin
            go = pending_frames.size() != 0 && !send_gap();
            if (go) begin
                fr = pending_frames.pop_front();
                s_tuser <= fr.finger;
                s_tdata <= {fr.t, fr.tz, fr.ty, fr.tx, fr.thz, fr.thy, fr.thx};
            end
            s_tvalid <= go;
        end
        m_tready <= !recv_stall();
    end

    always @(posedge aclk) begin
        frame_t   fr;
        gesture_t got, want;
        s_took = aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            got.finger_id = m_tuser;
            got.click     = m_tdata[0];
            got.stick_x   = m_tdata[16:1];
            got.stick_y   = m_tdata[32:17];
            got.held      = m_tdata[33];
            got.up        = m_tdata[34];
            got.down      = m_tdata[35];
            if (expected_gestures.size() == 0) begin
                $error("result transfer with none expected, finger %0d", m_tuser);
                errors++;
            end else begin
                want = expected_gestures.pop_front();
                compare_field("finger_id", want.finger_id, got.finger_id);
                compare_field("click", want.click, got.click);
                compare_field("stick_x", want.stick_x, got.stick_x);
                compare_field("stick_y", want.stick_y, got.stick_y);
                compare_field("stick_held", want.held, got.held);
                compare_field("swipe_up", want.up, got.up);
                compare_field("swipe_down", want.down, got.down);
            end
        end
        if (s_took) begin
            fr.finger = s_tuser;
            fr.thx = s_tdata[15:0];
            fr.thy = s_tdata[31:16];
            fr.thz = s_tdata[47:32];
            fr.tx  = s_tdata[63:48];
            fr.ty  = s_tdata[79:64];
            fr.tz  = s_tdata[95:80];
            fr.t   = s_tdata[127:96];
            expected_gestures.insert(expected_gestures.size(), classify(fr));
            n_accepted++;
        end
    end

    task automatic add_frame(logic [FINGER_W-1:0] f, int thx, int thy, int thz,
                             int tx, int ty, int tz, int unsigned t);
        frame_t fr;
        fr.finger = f;
        fr.thx = shortint'(thx);
        fr.thy = shortint'(thy);
        fr.thz = shortint'(thz);
        fr.tx  = shortint'(tx);
        fr.ty  = shortint'(ty);
        fr.tz  = shortint'(tz);
        fr.t   = t;
        pending_frames.insert(pending_frames.size(), fr);
        n_queued++;
    endtask

    function automatic int unsigned next_time();
        int unsigned t;
        t = clock_ms;
        if (chance(2)) clock_ms += $urandom;
        else clock_ms += rnd(0, hold_ms / 2 + 40);
        return t;
    endfunction

    // press, hold and move, release; repeated presses feed the double and locked modes
    task automatic add_gesture();
        logic [FINGER_W-1:0] f;
        int bx, by, bz, tx, ty, tz, span, h, sgn;
        f = FINGER_W'($urandom_range(3));
        span = 2 * ((stick_rng == 0) ? 1 : stick_rng);
        h = pinch_dist / 2;
        bx = rnd(-16000, 16000);
        by = rnd(-16000, 16000);
        bz = rnd(-16000, 16000);
        repeat ($urandom_range(1, 3)) begin
            repeat ($urandom_range(1, 5)) begin
                tx = bx + rnd(-span, span);
                ty = by + rnd(-span, span);
                tz = bz + rnd(-span, span);
                if (chance(5))
                    add_frame(f, tx + pinch_dist - 1, ty, tz, tx, ty, tz, next_time());
                else
                    add_frame(f, tx + rnd(-h, h), ty + rnd(-h, h), tz + rnd(-h, h),
                              tx, ty, tz, next_time());
            end
            repeat ($urandom_range(1, 2)) begin
                tx = bx + rnd(-span, span);
                ty = by + rnd(-span, span);
                tz = bz + rnd(-span, span);
                sgn = chance(50) ? 1 : -1;
                if (chance(10))
                    add_frame(f, tx + sgn * pinch_dist, ty, tz, tx, ty, tz, next_time());
                else
                    add_frame(f, tx + sgn * (pinch_dist + rnd(1, 2000)), ty + rnd(-h, h),
                              tz + rnd(-h, h), tx, ty, tz, next_time());
            end
        end
    endtask

    task automatic add_noise();
        add_frame(FINGER_W'($urandom_range(3)), $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_mode();
        if (chance(10)) return chance(50) ? MODE_NONE : MODE_UNUSED;
        return CFG_DATA_W'($urandom_range(MODE_PINCH, MODE_SWIPE));
    endfunction

    task automatic program_regs(reg_file_t regs);
        for (int i = 0; i <= CFG_HOLD_DELAY; i++) begin
            @(negedge aclk);
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_wdata <= regs[i];
            @(posedge aclk);
            apply_reg(CFG_IDX_W'(i), regs[i]);
        end
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (n_accepted != n_queued || expected_gestures.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        reg_file_t regs;
        int        goal;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        regs[CFG_MODE_FIRST]  = MODE_PINCH;
        regs[CFG_MODE_SECOND] = MODE_TIMED;
        regs[CFG_MODE_THIRD]  = MODE_DOUBLE;
        regs[CFG_MODE_FOURTH] = MODE_SWIPE;
        regs[CFG_PINCH_DIST]  = 320;
        regs[CFG_STICK_RANGE] = 800;
        regs[CFG_HOLD_DELAY]  = 500;
        program_regs(regs);
        add_frame(3, 32767, 32767, 32767, -32768, -32768, -32768, 32'hFFFF_FFFF);
        add_frame(0, 0, 0, 0, 0, 0, 0, 0);
        add_frame(0, 320, 0, 0, 0, 0, 0, 1);
        add_frame(0, 319, 0, 0, 0, 0, 0, 2);
        add_frame(1, 5, 5, 5, 0, 0, 0, 1000);
        add_frame(1, 5, 5, 5, 0, 0, 0, 1500);
        add_frame(1, 5, 5, 5, 0, 0, 0, 1501);
        add_frame(1, 2000, 0, 0, 0, 0, 0, 1502);
        add_frame(2, 100, 100, 100, 100, 100, 100, 10);
        add_frame(2, 9000, 100, 100, 100, 100, 100, 11);
        add_frame(2, 100, 100, 100, 100, 100, 100, 12);
        add_frame(2, 9000, 100, 100, 100, 100, 100, 13);
        add_frame(3, 0, 0, 0, 0, 0, 0, 20);
        add_frame(3, 0, -601, 0, 0, -601, 0, 21);
        add_frame(3, 0, 601, 0, 0, 601, 0, 22);
        add_frame(3, 0, 600, 0, 0, 600, 0, 23);
        drain();

        regs[CFG_MODE_FIRST]  = MODE_STICK;
        regs[CFG_MODE_SECOND] = MODE_LOCKED;
        regs[CFG_MODE_THIRD]  = MODE_NONE;
        regs[CFG_MODE_FOURTH] = MODE_UNUSED;
        regs[CFG_PINCH_DIST]  = 4095;
        regs[CFG_STICK_RANGE] = 0;
        regs[CFG_HOLD_DELAY]  = 65535;
        program_regs(regs);
        add_frame(0, 100, 100, 100, 100, 100, 100, 30);
        add_frame(0, 101, 100, 99, 101, 100, 99, 31);
        add_frame(1, 0, 0, 0, 0, 0, 0, 32);
        add_frame(1, 30000, 0, 0, 0, 0, 0, 33);
        add_frame(1, -50, 0, 50, -50, 0, 50, 34);
        add_frame(1, 30000, 0, 80, -20, 0, 80, 35);
        add_frame(2, 0, 0, 0, 0, 0, 0, 36);
        add_frame(3, 0, 0, 0, 0, 0, 0, 37);
        drain();

        regs[CFG_MODE_FIRST]  = MODE_PINCH;
        regs[CFG_MODE_SECOND] = MODE_PINCH;
        regs[CFG_MODE_THIRD]  = MODE_PINCH;
        regs[CFG_MODE_FOURTH] = MODE_PINCH;
        regs[CFG_PINCH_DIST]  = 0;
        regs[CFG_STICK_RANGE] = 4095;
        regs[CFG_HOLD_DELAY]  = 0;
        program_regs(regs);
        add_frame(0, 7, 7, 7, 7, 7, 7, 40);

        for (int ph = 0; ph < 8; ph++) begin
            drain();
            regs[CFG_MODE_FIRST]  = pick_mode();
            regs[CFG_MODE_SECOND] = pick_mode();
            regs[CFG_MODE_THIRD]  = pick_mode();
            regs[CFG_MODE_FOURTH] = pick_mode();
            regs[CFG_PINCH_DIST]  = CFG_DATA_W'(rnd(16, 1500));
            regs[CFG_STICK_RANGE] = CFG_DATA_W'(rnd(50, 2000));
            regs[CFG_HOLD_DELAY]  = CFG_DATA_W'(rnd(0, 2000));
            case (ph)
                0: begin
                    regs[CFG_PINCH_DIST]  = 4095;
                    regs[CFG_STICK_RANGE] = 4095;
                    regs[CFG_HOLD_DELAY]  = 65535;
                end
                1: begin
                    regs[CFG_PINCH_DIST]  = 1;
                    regs[CFG_STICK_RANGE] = 1;
                    regs[CFG_HOLD_DELAY]  = 0;
                end
                2: regs[CFG_STICK_RANGE] = 0;
                3: clock_ms = 32'hFFFF_8000;
                default: ;
            endcase
            idle_mode = ph % 4;
            program_regs(regs);
            goal = n_queued + 112;
            while (n_queued < goal) begin
                if (chance(15)) add_noise();
                else add_gesture();
            end
        end
        drain();

        if (errors == 0)
            $display("tb_pinch_gesture_classifier: done, clean");
        else
            $display("tb_pinch_gesture_classifier: done, errors");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_pinch_gesture_classifier: done, errors");
        $finish;
    end

endmodule

// File: sim.f
rtl/pgc_pkg.sv
rtl/pgc_axis_div.sv
rtl/pinch_gesture_classifier.sv
rtl/pgc_checker.sv
dv/tb_pinch_gesture_classifier.sv
